>>> sv/frnp_pkg.sv
`default_nettype none

package frnp_pkg;

  // default build
  localparam int unsigned MaxTaxelsDef = 64;
  localparam int unsigned CoordBitsDef = 16;

  // fixed field widths
  localparam int unsigned RadiusW = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned R2W     = 2 * RadiusW;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

endpackage

`default_nettype wire

>>> sv/frnp_ram.sv
`default_nettype none

module frnp_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/frnp_queue.sv
`default_nettype none

module frnp_queue #(
  parameter int unsigned WIDTH = 56
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(frnp_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(frnp_pkg::QueueDepth + 1);

  logic [WIDTH-1:0] slot_q [frnp_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(frnp_pkg::QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/frnp_front.sv
`default_nettype none

module frnp_front #(
  parameter int unsigned MAX_TAXELS = frnp_pkg::MaxTaxelsDef,
  parameter int unsigned COORD_BITS = frnp_pkg::CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          new_set_i,
  input  wire logic [COORD_BITS-1:0]         x_pos_i,
  input  wire logic [COORD_BITS-1:0]         y_pos_i,
  input  wire logic [COORD_BITS-1:0]         z_pos_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output logic [$clog2(MAX_TAXELS)+3*COORD_BITS:0] push_data_o
);

  localparam int unsigned IdxW = $clog2(MAX_TAXELS);
  localparam int unsigned CntW = $clog2(MAX_TAXELS + 1);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] count_eff;
  logic            full_drop;
  logic [IdxW-1:0] idx;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // index assignment and store-full check
  always_comb begin
    count_eff = new_set_i ? '0 : count_q;
    full_drop = (count_eff == CntW'(MAX_TAXELS));
    idx       = full_drop ? '0 : count_eff[IdxW-1:0];
    count_d   = count_q;
    if (push_o) begin
      count_d = full_drop ? count_eff : count_eff + CntW'(1);
    end
  end

  assign push_data_o = {full_drop, idx, x_pos_i, y_pos_i, z_pos_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/frnp_back.sv
`default_nettype none

module frnp_back #(
  parameter int unsigned MAX_TAXELS = frnp_pkg::MaxTaxelsDef,
  parameter int unsigned COORD_BITS = frnp_pkg::CoordBitsDef
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [frnp_pkg::RadiusW-1:0]          cfg_wdata_i,
  input  wire logic                                  q_valid_i,
  input  wire logic [$clog2(MAX_TAXELS)+3*COORD_BITS:0] q_data_i,
  output logic                                       q_pop_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [frnp_pkg::IndexW-1:0]                earlier_index_o,
  output logic [frnp_pkg::IndexW-1:0]                new_index_o,
  output logic                                       pair_valid_o,
  output logic                                       table_full_o,
  output logic                                       last_of_run_o
);

  localparam int unsigned IdxW  = $clog2(MAX_TAXELS);
  localparam int unsigned PosW  = 3 * COORD_BITS;
  localparam int unsigned DiffW = COORD_BITS + 1;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned SumW  = SqW + 2;
  localparam int unsigned CmpW  = (SumW > frnp_pkg::R2W) ? SumW : frnp_pkg::R2W;

  // queue head fields
  logic                  q_full;
  logic [IdxW-1:0]       q_idx;
  logic [PosW-1:0]       q_pos;

  assign q_full = q_data_i[IdxW+PosW];
  assign q_idx  = q_data_i[IdxW+PosW-1:PosW];
  assign q_pos  = q_data_i[PosW-1:0];

  // radius register and its square
  logic [frnp_pkg::RadiusW-1:0] radius_q;
  logic [frnp_pkg::R2W-1:0]     r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= '0;
      r2_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      r2_q <= frnp_pkg::R2W'(radius_q) * frnp_pkg::R2W'(radius_q);
    end
  end

  // whole pipeline moves when the output register can take a word
  logic adv;
  assign adv = !out_valid_o || !out_stall_i;

  // issue stage: one stored entry per cycle while the pipeline advances, then the closing op
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            issue;
  logic            is_close;
  logic            ram_we;
  logic [PosW-1:0] ram_rdata;

  assign issue    = q_valid_i && adv;
  assign is_close = (cnt_q == q_idx);
  assign q_pop_o  = issue && is_close;
  assign ram_we   = q_pop_o && !q_full;

  always_comb begin
    cnt_d = cnt_q;
    if (issue) begin
      cnt_d = is_close ? '0 : cnt_q + IdxW'(1);
    end
  end

  frnp_ram #(
    .WIDTH (PosW),
    .DEPTH (MAX_TAXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_idx),
    .wdata_i (q_pos),
    .re_i    (adv),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // stage 1: stored entry arrives, squares of differences
  logic                  v1_q, close1_q, full1_q;
  logic [IdxW-1:0]       ei1_q, ni1_q;
  logic [PosW-1:0]       np1_q;
  logic [SqW-1:0]        sq_d [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [COORD_BITS-1:0] a;
      logic [COORD_BITS-1:0] b;
      logic signed [DiffW-1:0] d;
      a = ram_rdata[k*COORD_BITS +: COORD_BITS];
      b = np1_q[k*COORD_BITS +: COORD_BITS];
      d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
      sq_d[k] = $unsigned(SqW'(d) * SqW'(d));
    end
  end

  // stage 2: sum and compare
  logic                  v2_q, close2_q, full2_q, org2_q;
  logic [IdxW-1:0]       ei2_q, ni2_q;
  logic [SqW-1:0]        sq2_q [3];
  logic [SumW-1:0]       sum2;
  logic                  hit2;

  assign sum2 = SumW'(sq2_q[0]) + SumW'(sq2_q[1]) + SumW'(sq2_q[2]);
  assign hit2 = (CmpW'(sum2) <= CmpW'(r2_q));

  // output word
  logic                        out_valid_q;
  logic [frnp_pkg::IndexW-1:0] out_ei_q, out_ni_q;
  logic                        out_pv_q, out_tf_q, out_last_q;
  logic                        emit2;

  assign emit2 = v2_q && (close2_q || (!org2_q && hit2));

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      cnt_q       <= cnt_d;
      v1_q        <= issue;
      v2_q        <= v1_q;
      out_valid_q <= emit2;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      close1_q <= is_close;
      full1_q  <= q_full;
      ei1_q    <= cnt_q;
      ni1_q    <= q_idx;
      np1_q    <= q_pos;

      close2_q <= close1_q;
      full2_q  <= full1_q;
      org2_q   <= (ram_rdata == '0);
      ei2_q    <= ei1_q;
      ni2_q    <= ni1_q;
      for (int k = 0; k < 3; k++) begin
        sq2_q[k] <= sq_d[k];
      end

      out_ei_q   <= close2_q ? '0 : frnp_pkg::IndexW'(ei2_q);
      out_ni_q   <= frnp_pkg::IndexW'(ni2_q);
      out_pv_q   <= !close2_q;
      out_tf_q   <= close2_q && full2_q;
      out_last_q <= close2_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign earlier_index_o = out_ei_q;
  assign new_index_o     = out_ni_q;
  assign pair_valid_o    = out_pv_q;
  assign table_full_o    = out_tf_q;
  assign last_of_run_o   = out_last_q;

  // a pair always names an earlier taxel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_valid_o |-> earlier_index_o < new_index_o && !last_of_run_o)
    else $error("pair word with bad indexes");

  // a dropped item gives only a closing word at index zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> last_of_run_o && new_index_o == '0 && !pair_valid_o)
    else $error("malformed store-full word");

  // the sweep never runs past the item's own index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid_i |-> cnt_q <= q_idx)
    else $error("sweep counter past new index");

  // a held output freezes the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(v1_q) && $stable(v2_q) && $stable(cnt_q))
    else $error("pipeline moved under output stall");

endmodule

`default_nettype wire

>>> sv/fixed_radius_neighbor_pairs.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_stall_o    new_set_i, x_pos_i, y_pos_i, z_pos_i
// out       output     out_valid_o / out_stall_i  earlier_index_o, new_index_o, pair_valid_o,
//                                                  table_full_o, last_of_run_o
// cfg       input      cfg_we_i                   cfg_wdata_i (radius)
//
// an item with new index n is issued in the back end as a sweep over stored entries
// 0 to n-1, one per cycle while the back end is not stalled, through the single read
// port of the position store, then the closing step, which writes the new position
// unless the item was dropped; each step then passes stage 1, stage 2 and the output register
// reset clears counts and valid bits; the position store is not cleared
// an output stall freezes the whole back end; the front keeps taking words
// until the two-entry command queue is full
`default_nettype none

module fixed_radius_neighbor_pairs #(
  parameter int unsigned MAX_TAXELS = frnp_pkg::MaxTaxelsDef,
  parameter int unsigned COORD_BITS = frnp_pkg::CoordBitsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [frnp_pkg::RadiusW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          new_set_i,
  input  wire logic signed [COORD_BITS-1:0]  x_pos_i,
  input  wire logic signed [COORD_BITS-1:0]  y_pos_i,
  input  wire logic signed [COORD_BITS-1:0]  z_pos_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [frnp_pkg::IndexW-1:0]        earlier_index_o,
  output logic [frnp_pkg::IndexW-1:0]        new_index_o,
  output logic                               pair_valid_o,
  output logic                               table_full_o,
  output logic                               last_of_run_o
);

  localparam int unsigned CmdW = $clog2(MAX_TAXELS) + 3 * COORD_BITS + 1;

  logic            push;
  logic [CmdW-1:0] push_data;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic [CmdW-1:0] q_data;

  // front: index assignment and full check
  frnp_front #(
    .MAX_TAXELS (MAX_TAXELS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .new_set_i   (new_set_i),
    .x_pos_i     (x_pos_i),
    .y_pos_i     (y_pos_i),
    .z_pos_i     (z_pos_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // command queue
  frnp_queue #(
    .WIDTH (CmdW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // back: store sweep, distance test, result words
  frnp_back #(
    .MAX_TAXELS (MAX_TAXELS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .earlier_index_o (earlier_index_o),
    .new_index_o     (new_index_o),
    .pair_valid_o    (pair_valid_o),
    .table_full_o    (table_full_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

`default_nettype wire
